### rtl/core/brc_pkg.sv
`timescale 1ns / 1ps

package brc_pkg;

	localparam int LIMIT_BITS   = 17;
	localparam int OUT_CNT_BITS = 16;
	localparam logic [OUT_CNT_BITS-1:0] OUT_CNT_MAX = 16'hFFFF;

	// Input opcodes.
	localparam logic OP_SPEC = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Spec forms.
	localparam logic [1:0] FORM_SUFFIX = 2'd0;
	localparam logic [1:0] FORM_OPEN   = 2'd1;
	localparam logic [1:0] FORM_CLOSED = 2'd2;
	localparam logic [1:0] FORM_ERROR  = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_RANGE   = 2'd0;
	localparam logic [1:0] KIND_DISCARD = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// Verdicts.
	localparam logic [1:0] VERDICT_PARTIAL = 2'd0;
	localparam logic [1:0] VERDICT_IGNORE  = 2'd1;
	localparam logic [1:0] VERDICT_UNSAT   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_CONTENT_LENGTH = 2'd0;
	localparam logic [1:0] REG_RANGE_LIMIT    = 2'd1;
	localparam logic [1:0] REG_OVERLAP_LIMIT  = 2'd2;
	localparam logic [1:0] REG_REVERSAL_LIMIT = 2'd3;

	localparam logic [LIMIT_BITS-1:0] RANGE_LIMIT_RST    = 17'd200;
	localparam logic [LIMIT_BITS-1:0] OVERLAP_LIMIT_RST  = 17'd20;
	localparam logic [LIMIT_BITS-1:0] REVERSAL_LIMIT_RST = 17'd20;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] range_limit;
		logic [LIMIT_BITS-1:0] overlap_limit;
		logic [LIMIT_BITS-1:0] reversal_limit;
	} limits_t;

endpackage

### rtl/core/brc_outq.sv
`timescale 1ns / 1ps

module brc_outq #(
	parameter int WIDTH = 155
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push0,
	input  logic [WIDTH-1:0] data0,
	input  logic             push1,
	input  logic [WIDTH-1:0] data1,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             not_empty,
	output logic             room
);

	localparam int DEPTH = 4;
	localparam int AW    = 2;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      count_q;
	logic [AW-1:0]    wp_next1;
	logic [AW:0]      n_push;
	logic             do_pop;

	assign wp_next1  = wp_q + 1'b1;
	assign not_empty = (count_q != '0);
	assign room      = (count_q <= (AW+1)'(DEPTH - 2));
	assign head      = mem_q[rp_q];
	assign do_pop    = pop && not_empty;
	assign n_push    = (AW+1)'(push0) + (AW+1)'(push1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wp_q] <= data0;
		end
		if (push1) begin
			mem_q[wp_next1] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + n_push[AW-1:0];
			rp_q    <= rp_q + AW'(do_pop);
			count_q <= count_q + n_push - (AW+1)'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("result queue count exceeds its depth");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second result pushed without a first");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> (count_q <= (AW+1)'(DEPTH - 2)))
		else $error("result pushed without room for two items");

endmodule

### rtl/core/brc_core.sv
`timescale 1ns / 1ps

module brc_core #(
	parameter int OFFSET_BITS = 48,
	parameter int COUNT_BITS  = 16,
	parameter int DATA_BITS   = 152
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_opcode,
	input  logic [1:0]             in_form,
	input  logic [OFFSET_BITS-1:0] in_a,
	input  logic [OFFSET_BITS-1:0] in_b,
	input  logic [OFFSET_BITS-1:0] clen,
	input  logic [OFFSET_BITS-1:0] clen_m1,
	input  brc_pkg::limits_t       lim,
	output logic                   res0_valid,
	output logic [DATA_BITS+2:0]   res0,
	output logic                   res1_valid,
	output logic [DATA_BITS+2:0]   res1
);

	localparam int OB    = OFFSET_BITS;
	localparam int CB    = COUNT_BITS;
	localparam int CW    = (CB > brc_pkg::OUT_CNT_BITS) ? CB : brc_pkg::OUT_CNT_BITS;
	localparam int EW    = DATA_BITS + 3;
	localparam int V_LO  = 2 * OB;
	localparam int C0_LO = V_LO + 2;
	localparam int C1_LO = C0_LO + brc_pkg::OUT_CNT_BITS;
	localparam int C2_LO = C1_LO + brc_pkg::OUT_CNT_BITS;

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic over_limit(input logic [CB-1:0] t,
					    input logic [brc_pkg::LIMIT_BITS-1:0] l);
		logic [CW-1:0] te;
		logic [CW-1:0] le;
		te = CW'(t);
		le = CW'(l[brc_pkg::LIMIT_BITS-2:0]);
		return !l[brc_pkg::LIMIT_BITS-1] && (te > le);
	endfunction

	function automatic logic [brc_pkg::OUT_CNT_BITS-1:0] out16(input logic [CB-1:0] t);
		logic [CW-1:0] te;
		te = CW'(t);
		return (te > CW'(brc_pkg::OUT_CNT_MAX)) ? brc_pkg::OUT_CNT_MAX
			: te[brc_pkg::OUT_CNT_BITS-1:0];
	endfunction

	function automatic logic [EW-1:0] pack(input logic [1:0] kind,
					       input logic [OB-1:0] first,
					       input logic [OB-1:0] last,
					       input logic [1:0] vd,
					       input logic [brc_pkg::OUT_CNT_BITS-1:0] c0,
					       input logic [brc_pkg::OUT_CNT_BITS-1:0] c1,
					       input logic [brc_pkg::OUT_CNT_BITS-1:0] c2,
					       input logic lastf);
		logic [DATA_BITS-1:0] d;
		d = '0;
		d[OB-1:0] = first;
		d[2*OB-1:OB] = last;
		d[V_LO+1:V_LO] = vd;
		d[C0_LO+brc_pkg::OUT_CNT_BITS-1:C0_LO] = c0;
		d[C1_LO+brc_pkg::OUT_CNT_BITS-1:C1_LO] = c1;
		d[C2_LO+brc_pkg::OUT_CNT_BITS-1:C2_LO] = c2;
		return {lastf, kind, d};
	endfunction

	// Header state.
	logic [OB-1:0] open_first_q, open_first_n;
	logic [OB-1:0] open_last_q, open_last_n;
	logic          open_valid_q, open_valid_n;
	logic [CB-1:0] rtally_q, rtally_n;
	logic [CB-1:0] otally_q, otally_n;
	logic [CB-1:0] vtally_q, vtally_n;
	logic [OB:0]   sum_q, sum_n;
	logic          unsat_q, unsat_n;
	logic          rej_q, rej_n;
	logic          whole_q, whole_n;

	logic          is_end;
	logic          clen_zero;
	logic          blocked;
	logic          bad;
	logic          whole;
	logic [OB-1:0] start;
	logic [OB-1:0] stop;
	logic [OB-1:0] stop_c;
	logic          unsat;
	logic          in_cover;
	logic          rev;
	logic          ext;
	logic          merged;
	logic [OB+1:0] sum_raw;
	logic [OB:0]   flush_sum;
	logic [CB-1:0] rt_inc;
	logic          end_flush;
	logic [CB-1:0] rt_fin;
	logic [OB:0]   sum_fin;
	logic          none_unsat;
	logic [1:0]    verdict;
	logic [EW-1:0] range_entry;
	logic [EW-1:0] verdict_entry;
	logic [EW-1:0] discard_entry;

	assign is_end    = (in_opcode == brc_pkg::OP_END);
	assign clen_zero = (clen == '0);
	assign blocked   = rej_q || whole_q || clen_zero;

	always_comb begin
		bad   = 1'b0;
		whole = 1'b0;
		start = in_a;
		stop  = clen_m1;
		case (in_form)
			brc_pkg::FORM_SUFFIX: begin
				bad   = (in_a == '0);
				start = (in_a >= clen) ? '0 : clen - in_a;
			end
			brc_pkg::FORM_OPEN: begin
				whole = (in_a == '0);
			end
			brc_pkg::FORM_CLOSED: begin
				bad  = (in_a > in_b);
				stop = in_b;
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	assign unsat  = (start >= clen);
	assign stop_c = (stop >= clen) ? clen_m1 : stop;

	assign in_cover = (start >= open_first_q) && (stop_c <= open_last_q);
	assign rev      = (start < open_first_q) &&
			  (({1'b0, stop_c} + 1'b1) >= {1'b0, open_first_q});
	assign ext      = (stop_c >= open_last_q) &&
			  ({1'b0, start} <= ({1'b0, open_last_q} + 1'b1));
	assign merged   = in_cover || rev || ext;

	// Length sum plus the open range length, as one four-operand add.
	assign sum_raw   = (OB+2)'(sum_q) + (OB+2)'(open_last_q) - (OB+2)'(open_first_q)
			   + (OB+2)'(1);
	assign flush_sum = sum_raw[OB+1] ? '1 : sum_raw[OB:0];
	assign rt_inc    = sat_inc(rtally_q);

	assign end_flush  = !rej_q && !clen_zero && open_valid_q;
	assign rt_fin     = end_flush ? rt_inc : rtally_q;
	assign sum_fin    = end_flush ? flush_sum : sum_q;
	assign none_unsat = !open_valid_q && (rtally_q == '0) && unsat_q;

	always_comb begin
		if (rej_q || clen_zero) begin
			verdict = brc_pkg::VERDICT_IGNORE;
		end else if (over_limit(otally_q, lim.overlap_limit) ||
			     over_limit(vtally_q, lim.reversal_limit)) begin
			verdict = brc_pkg::VERDICT_IGNORE;
		end else if (none_unsat) begin
			verdict = brc_pkg::VERDICT_UNSAT;
		end else if ((sum_fin > {1'b0, clen}) || (rt_fin == '0) ||
			     over_limit(rt_fin, lim.range_limit)) begin
			verdict = brc_pkg::VERDICT_IGNORE;
		end else begin
			verdict = brc_pkg::VERDICT_PARTIAL;
		end
	end

	assign range_entry   = pack(brc_pkg::KIND_RANGE, open_first_q, open_last_q,
				    brc_pkg::VERDICT_PARTIAL, '0, '0, '0, !is_end);
	assign verdict_entry = pack(brc_pkg::KIND_VERDICT, '0, '0, verdict,
				    out16(rt_fin), out16(otally_q), out16(vtally_q), 1'b1);
	assign discard_entry = pack(brc_pkg::KIND_DISCARD, '0, clen_m1,
				    brc_pkg::VERDICT_PARTIAL, '0, '0, '0, 1'b1);

	always_comb begin
		if (is_end) begin
			res0 = end_flush ? range_entry : verdict_entry;
		end else begin
			res0 = whole ? discard_entry : range_entry;
		end
		res1 = verdict_entry;
	end

	always_comb begin
		open_first_n = open_first_q;
		open_last_n  = open_last_q;
		open_valid_n = open_valid_q;
		rtally_n     = rtally_q;
		otally_n     = otally_q;
		vtally_n     = vtally_q;
		sum_n        = sum_q;
		unsat_n      = unsat_q;
		rej_n        = rej_q;
		whole_n      = whole_q;
		res0_valid   = 1'b0;
		res1_valid   = 1'b0;
		if (in_valid) begin
			if (is_end) begin
				res0_valid   = 1'b1;
				res1_valid   = end_flush;
				open_first_n = '0;
				open_last_n  = '0;
				open_valid_n = 1'b0;
				rtally_n     = '0;
				otally_n     = '0;
				vtally_n     = '0;
				sum_n        = '0;
				unsat_n      = 1'b0;
				rej_n        = 1'b0;
				whole_n      = 1'b0;
			end else if (!blocked) begin
				if (bad) begin
					rej_n = 1'b1;
				end else if (whole) begin
					rtally_n     = '0;
					sum_n        = '0;
					open_first_n = '0;
					open_last_n  = clen_m1;
					open_valid_n = 1'b1;
					whole_n      = 1'b1;
					res0_valid   = 1'b1;
				end else if (unsat) begin
					unsat_n = 1'b1;
				end else if (!open_valid_q) begin
					open_first_n = start;
					open_last_n  = stop_c;
					open_valid_n = 1'b1;
				end else if (merged) begin
					if (rev) begin
						open_first_n = start;
						vtally_n     = sat_inc(vtally_q);
					end
					if (ext) begin
						open_last_n = stop_c;
					end
					otally_n = sat_inc(otally_q);
				end else begin
					res0_valid   = 1'b1;
					rtally_n     = rt_inc;
					sum_n        = flush_sum;
					open_first_n = start;
					open_last_n  = stop_c;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_first_q <= '0;
			open_last_q  <= '0;
			open_valid_q <= 1'b0;
			rtally_q     <= '0;
			otally_q     <= '0;
			vtally_q     <= '0;
			sum_q        <= '0;
			unsat_q      <= 1'b0;
			rej_q        <= 1'b0;
			whole_q      <= 1'b0;
		end else begin
			open_first_q <= open_first_n;
			open_last_q  <= open_last_n;
			open_valid_q <= open_valid_n;
			rtally_q     <= rtally_n;
			otally_q     <= otally_n;
			vtally_q     <= vtally_n;
			sum_q        <= sum_n;
			unsat_q      <= unsat_n;
			rej_q        <= rej_n;
			whole_q      <= whole_n;
		end
	end

	a_whole_is_open: assert property (@(posedge clk) disable iff (!arst_n)
		whole_q |-> open_valid_q)
		else $error("whole body taken without an open range");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && is_end) |=> (!open_valid_q && !rej_q && !whole_q && (rtally_q == '0)))
		else $error("header state not cleared after an end item");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		res1_valid |-> (res0_valid && is_end))
		else $error("second result without a flushed range");

endmodule

### rtl/core/byte_range_coalescer.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register, and its results are then written to the
// result queue once the queue has room, from whose head they are taken. The input takes one
// item per cycle but stalls while the four-entry result queue holds more than two results,
// which only a run of items with two results each or a stalled output causes.
// Reset clears the header state and the queue and loads the default configuration.

module byte_range_coalescer #(
	parameter int OFFSET_BITS = 48,
	parameter int COUNT_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,

	// Configuration write channel.
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [((OFFSET_BITS > brc_pkg::LIMIT_BITS) ? OFFSET_BITS
		      : brc_pkg::LIMIT_BITS)-1:0] cfg_data,

	input  logic s_tvalid,
	output logic s_tready,
	// first_value, second_value, zero fill.
	input  logic [((2*OFFSET_BITS+7)/8)*8-1:0] s_tdata,
	// opcode, spec_form.
	input  logic [2:0] s_tuser,

	output logic m_tvalid,
	input  logic m_tready,
	// range_first, range_last, verdict, merged_count, overlap_total, reversal_total,
	// zero fill.
	output logic [((2*OFFSET_BITS+2+3*brc_pkg::OUT_CNT_BITS+7)/8)*8-1:0] m_tdata,
	// result_kind.
	output logic [1:0] m_tuser,
	output logic m_tlast
);

	localparam int OB        = OFFSET_BITS;
	localparam int DATA_BITS = ((2*OB + 2 + 3*brc_pkg::OUT_CNT_BITS + 7) / 8) * 8;
	localparam int EW        = DATA_BITS + 3;

	logic [OB-1:0]    clen_q;
	logic [OB-1:0]    clen_m1_q;
	brc_pkg::limits_t lim_q;

	logic          valid_s1;
	logic          opcode_s1;
	logic [1:0]    form_s1;
	logic [OB-1:0] a_s1;
	logic [OB-1:0] b_s1;

	logic          room;
	logic          advance;
	logic          res0_valid;
	logic          res1_valid;
	logic [EW-1:0] res0;
	logic [EW-1:0] res1;
	logic [EW-1:0] head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clen_q                <= OB'(1);
			clen_m1_q             <= '0;
			lim_q.range_limit     <= brc_pkg::RANGE_LIMIT_RST;
			lim_q.overlap_limit   <= brc_pkg::OVERLAP_LIMIT_RST;
			lim_q.reversal_limit  <= brc_pkg::REVERSAL_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				brc_pkg::REG_CONTENT_LENGTH: begin
					clen_q    <= cfg_data[OB-1:0];
					clen_m1_q <= cfg_data[OB-1:0] - 1'b1;
				end
				brc_pkg::REG_RANGE_LIMIT: begin
					lim_q.range_limit <= cfg_data[brc_pkg::LIMIT_BITS-1:0];
				end
				brc_pkg::REG_OVERLAP_LIMIT: begin
					lim_q.overlap_limit <= cfg_data[brc_pkg::LIMIT_BITS-1:0];
				end
				brc_pkg::REG_REVERSAL_LIMIT: begin
					lim_q.reversal_limit <= cfg_data[brc_pkg::LIMIT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1 <= s_tuser[0];
			form_s1   <= s_tuser[2:1];
			a_s1      <= s_tdata[OB-1:0];
			b_s1      <= s_tdata[2*OB-1:OB];
		end
	end

	brc_core #(
		.OFFSET_BITS (OFFSET_BITS),
		.COUNT_BITS  (COUNT_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (advance),
		.in_opcode  (opcode_s1),
		.in_form    (form_s1),
		.in_a       (a_s1),
		.in_b       (b_s1),
		.clen       (clen_q),
		.clen_m1    (clen_m1_q),
		.lim        (lim_q),
		.res0_valid (res0_valid),
		.res0       (res0),
		.res1_valid (res1_valid),
		.res1       (res1)
	);

	brc_outq #(
		.WIDTH (EW)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (res0_valid),
		.data0     (res0),
		.push1     (res1_valid),
		.data1     (res1),
		.pop       (m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.room      (room)
	);

	assign m_tdata = head[DATA_BITS-1:0];
	assign m_tuser = head[DATA_BITS+1:DATA_BITS];
	assign m_tlast = head[DATA_BITS+2];

endmodule
